// File: design/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants for running sample statistics
// sequencer states, control/status bundles and width helpers
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

	// fixed result field widths
	localparam int unsigned CROSS_W = 16;
	localparam int unsigned VAR_W   = 31;
	localparam int unsigned ROOT_W  = 16;

	// command codes carried on tuser
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [3:0] {
		E_IDLE,
		E_SQUARE,
		E_ACCUM,
		E_PREP,
		E_DIV_MEAN,
		E_DIV_MSQ,
		E_QSQ,
		E_VAR,
		E_SQRT_VAR,
		E_SQRT_MSQ,
		E_DONE
	} eng_state_t;

	typedef struct packed {
		logic start;
		logic add;
		logic ack;
	} eng_ctrl_t;

	typedef struct packed {
		logic idle;
		logic done;
		logic acc_en;
	} eng_stat_t;

	// sum of squares width, wraps at 64 bits
	function automatic int sq_width(input int sb, input int cb);
		int w;
		w = 2 * sb + cb;
		return (w > 64) ? 64 : w;
	endfunction

	// root width for a value of sqw bits
	function automatic int root_width(input int sqw);
		return (sqw + 1) >> 1;
	endfunction

endpackage

`default_nettype wire

// File: design/rss_cs_unit.sv
// ----------------------------------------------------------------------------
// rss_cs_unit: shared compare-subtract unit
// a - b with borrow out, used by division, square root and variance steps
// ----------------------------------------------------------------------------
`default_nettype none

module rss_cs_unit #(
	parameter int WIDTH = 48
) (
	input  wire logic [WIDTH-1:0] a,
	input  wire logic [WIDTH-1:0] b,
	output logic      [WIDTH-1:0] diff,
	output logic                  borrow
);

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

`default_nettype wire

// File: design/rss_engine.sv
// ----------------------------------------------------------------------------
// rss_engine: statistics sequencer
// squares the sample, divides sum and sum of squares by count, forms the
// variance and takes two roots, all but squaring on one compare-subtract unit
// ----------------------------------------------------------------------------
`default_nettype none

module rss_engine
	import rss_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16,
	localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS,
	localparam int SQ_W   = sq_width(SAMPLE_BITS, COUNT_BITS),
	localparam int RT_W   = root_width(SQ_W),
	localparam int PROD_W = 2 * SAMPLE_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire eng_ctrl_t                ctrl,
	output eng_stat_t                     stat,
	input  wire logic [SAMPLE_BITS-1:0]   mag,
	input  wire logic [COUNT_BITS-1:0]    count,
	input  wire logic signed [SUM_W-1:0]  sum,
	input  wire logic [SQ_W-1:0]          sum_sq,
	output logic [PROD_W-1:0]             prod,
	output logic [SAMPLE_BITS-1:0]        mean,
	output logic [SQ_W-1:0]               variance,
	output logic [RT_W-1:0]               std_dev,
	output logic [RT_W-1:0]               rms
);

	localparam int RT_IN  = 2 * RT_W;
	localparam int RM_W   = RT_W + 2;
	localparam int REM_W  = (COUNT_BITS > RM_W) ? COUNT_BITS : RM_W;
	localparam int ITER_W = $clog2(SQ_W);

	eng_state_t state_q, state_d;

	logic [ITER_W-1:0]      iter_q;
	logic [RT_IN-1:0]       sh_q;
	logic [REM_W-1:0]       rem_q;
	logic [SQ_W-1:0]        acc_q;
	logic [SAMPLE_BITS-1:0] op_q;
	logic [PROD_W-1:0]      prod_q;
	logic                   neg_q;
	logic [SAMPLE_BITS-1:0] mean_q;
	logic [SQ_W-1:0]        msq_q;
	logic [SQ_W-1:0]        var_q;
	logic [RT_W-1:0]        std_q;
	logic [RT_W-1:0]        rms_q;

	logic [SQ_W-1:0]        unit_a, unit_b, unit_diff;
	logic                   unit_borrow;
	logic [COUNT_BITS:0]    div_rsh;
	logic [RM_W-1:0]        rt_rsh;
	logic [SQ_W-1:0]        acc_nxt;
	logic [REM_W-1:0]       rem_nxt;
	logic [SUM_W-1:0]       smag;
	logic [SAMPLE_BITS-1:0] q_nxt;
	logic [SQ_W-1:0]        var_nxt;
	logic                   iter_last;

	rss_cs_unit #(
		.WIDTH(SQ_W)
	) u_cs (
		.a     (unit_a),
		.b     (unit_b),
		.diff  (unit_diff),
		.borrow(unit_borrow)
	);

	assign div_rsh   = {rem_q[COUNT_BITS-1:0], sh_q[SQ_W-1]};
	assign rt_rsh    = {rem_q[RT_W-1:0], sh_q[RT_IN-1 -: 2]};
	assign acc_nxt   = {acc_q[SQ_W-2:0], ~unit_borrow};
	assign rem_nxt   = unit_borrow ? REM_W'(unit_a) : REM_W'(unit_diff);
	assign smag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
	assign q_nxt     = SAMPLE_BITS'(acc_nxt);
	assign var_nxt   = unit_borrow ? '0 : unit_diff;
	assign iter_last = (iter_q == '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			E_IDLE: begin
				if (ctrl.start) begin
					state_d = ctrl.add ? E_SQUARE : E_PREP;
				end
			end
			E_SQUARE:   state_d = E_ACCUM;
			E_ACCUM:    state_d = E_PREP;
			E_PREP:     state_d = (count == '0) ? E_DONE : E_DIV_MEAN;
			E_DIV_MEAN: if (iter_last) state_d = E_DIV_MSQ;
			E_DIV_MSQ:  if (iter_last) state_d = E_QSQ;
			E_QSQ:      state_d = E_VAR;
			E_VAR:      state_d = E_SQRT_VAR;
			E_SQRT_VAR: if (iter_last) state_d = E_SQRT_MSQ;
			E_SQRT_MSQ: if (iter_last) state_d = E_DONE;
			E_DONE:     if (ctrl.ack) state_d = E_IDLE;
			default:    state_d = E_IDLE;
		endcase
	end

	// outputs and shared unit operand select
	always_comb begin
		stat.idle   = (state_q == E_IDLE);
		stat.done   = (state_q == E_DONE);
		stat.acc_en = (state_q == E_ACCUM);
		unique case (state_q)
			E_DIV_MEAN, E_DIV_MSQ: begin
				unit_a = SQ_W'(div_rsh);
				unit_b = SQ_W'(count);
			end
			E_SQRT_VAR, E_SQRT_MSQ: begin
				unit_a = SQ_W'(rt_rsh);
				unit_b = SQ_W'({acc_q[RT_W-1:0], 2'b01});
			end
			E_VAR: begin
				unit_a = msq_q;
				unit_b = SQ_W'(prod_q);
			end
			default: begin
				unit_a = '0;
				unit_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				E_PREP:     iter_q <= ITER_W'(SQ_W - 1);
				E_DIV_MEAN: iter_q <= iter_last ? ITER_W'(SQ_W - 1) : iter_q - 1'b1;
				E_DIV_MSQ:  iter_q <= iter_q - 1'b1;
				E_VAR:      iter_q <= ITER_W'(RT_W - 1);
				E_SQRT_VAR: iter_q <= iter_last ? ITER_W'(RT_W - 1) : iter_q - 1'b1;
				E_SQRT_MSQ: iter_q <= iter_q - 1'b1;
				default:    iter_q <= iter_q;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			E_IDLE: begin
				if (ctrl.start) begin
					op_q <= mag;
				end
			end
			E_SQUARE, E_QSQ: begin
				prod_q <= op_q * op_q;
			end
			E_PREP: begin
				sh_q   <= RT_IN'(smag);
				rem_q  <= '0;
				acc_q  <= '0;
				neg_q  <= sum[SUM_W-1];
				mean_q <= '0;
				var_q  <= '0;
				std_q  <= '0;
				rms_q  <= '0;
			end
			E_DIV_MEAN: begin
				if (iter_last) begin
					op_q   <= q_nxt;
					mean_q <= neg_q ? SAMPLE_BITS'(-q_nxt) : q_nxt;
					sh_q   <= RT_IN'(sum_sq);
					rem_q  <= '0;
					acc_q  <= '0;
				end else begin
					sh_q  <= {sh_q[RT_IN-2:0], 1'b0};
					rem_q <= rem_nxt;
					acc_q <= acc_nxt;
				end
			end
			E_DIV_MSQ: begin
				sh_q  <= {sh_q[RT_IN-2:0], 1'b0};
				rem_q <= rem_nxt;
				acc_q <= acc_nxt;
				if (iter_last) begin
					msq_q <= acc_nxt;
				end
			end
			E_VAR: begin
				var_q <= var_nxt;
				sh_q  <= RT_IN'(var_nxt);
				rem_q <= '0;
				acc_q <= '0;
			end
			E_SQRT_VAR: begin
				if (iter_last) begin
					std_q <= RT_W'(acc_nxt);
					sh_q  <= RT_IN'(msq_q);
					rem_q <= '0;
					acc_q <= '0;
				end else begin
					sh_q  <= {sh_q[RT_IN-3:0], 2'b00};
					rem_q <= rem_nxt;
					acc_q <= acc_nxt;
				end
			end
			E_SQRT_MSQ: begin
				sh_q  <= {sh_q[RT_IN-3:0], 2'b00};
				rem_q <= rem_nxt;
				acc_q <= acc_nxt;
				if (iter_last) begin
					rms_q <= RT_W'(acc_nxt);
				end
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

	assign prod     = prod_q;
	assign mean     = mean_q;
	assign variance = var_q;
	assign std_dev  = std_q;
	assign rms      = rms_q;

endmodule

`default_nettype wire

// File: design/running_sample_statistics.sv
// ----------------------------------------------------------------------------
// running_sample_statistics: running count, mean, variance, min, max, rms
// streaming statistics over signed fixed-point samples with a clear command
// ----------------------------------------------------------------------------
// Each input transaction carries one signed sample (Q8.8 at the default
// width) and a command on tuser: add the sample, or clear every statistic.
// Exactly one output transaction follows every input transaction and reports
// the count, minimum, maximum, zero-crossing count, truncated mean, variance
// (mean square minus squared mean, floored at zero), standard deviation and
// rms, all reading zero while the count is zero. Once the count saturates,
// added samples are dropped and the full flag is set. The block works on one
// transaction at a time: s_tready is high only while the sequencer is idle.
// Unless the count is zero, each transaction runs two bit-serial divisions
// by the count and two digit-by-digit square roots on a single shared
// compare-subtract unit; a dropped sample has no square to fold in, and a
// clear leaves the count at zero and skips the arithmetic. The sum of squares
// is SQ_W = min(2*SAMPLE_BITS + COUNT_BITS, 64) bits wide and the roots are
// RT_W = ceil(SQ_W/2) bits. While the result side holds off, the finished
// result waits in the sequencer. A finished result waits in the output
// register while the next transaction is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module running_sample_statistics
	import rss_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16,
	localparam int IN_W   = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int DATA_W = COUNT_BITS + 3 * SAMPLE_BITS + VAR_W + 2 * ROOT_W + CROSS_W + 1,
	localparam int OUT_W  = ((DATA_W + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,   // sample
	input  wire logic              s_tuser,   // cmd
	// result stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata    // sample_count, minimum, maximum, mean,
	                                          // variance, std_dev, rms, crossings,
	                                          // full_res
);

	localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
	localparam int SQ_W   = sq_width(SAMPLE_BITS, COUNT_BITS);
	localparam int RT_W   = root_width(SQ_W);
	localparam int PROD_W = 2 * SAMPLE_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [CROSS_W-1:0]    CROSS_MAX = {CROSS_W{1'b1}};

	// statistics state
	logic [COUNT_BITS-1:0]         count_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SQ_W-1:0]               sum_sq_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic [CROSS_W-1:0]            cross_q;

	// output register
	logic                          m_tvalid_q;
	logic [OUT_W-1:0]              m_tdata_q;

	logic signed [SAMPLE_BITS-1:0] sample;
	logic [SAMPLE_BITS-1:0]        mag;
	logic                          accept;
	logic                          add_ok;
	logic                          crossed;
	logic                          out_load;
	logic                          full;

	eng_ctrl_t                     eng_ctrl;
	eng_stat_t                     eng_stat;
	logic [PROD_W-1:0]             eng_prod;
	logic [SAMPLE_BITS-1:0]        eng_mean;
	logic [SQ_W-1:0]               eng_var;
	logic [RT_W-1:0]               eng_std;
	logic [RT_W-1:0]               eng_rms;

	assign sample   = s_tdata[SAMPLE_BITS-1:0];
	assign mag      = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
	assign s_tready = eng_stat.idle;
	assign accept   = s_tvalid && s_tready;
	// a sample is taken only while the count has room
	assign add_ok   = (s_tuser == CMD_ADD) && (count_q != CNT_MAX);
	// strictly positive to strictly negative or the other way round
	assign crossed  = ((!prev_q[SAMPLE_BITS-1] && prev_q != '0) && sample[SAMPLE_BITS-1])
	               || (prev_q[SAMPLE_BITS-1] && (!sample[SAMPLE_BITS-1] && sample != '0));
	assign full     = (count_q == CNT_MAX);
	// result moves to the output register once it is free
	assign out_load = eng_stat.done && (!m_tvalid_q || m_tready);

	assign eng_ctrl.start = accept;
	assign eng_ctrl.add   = add_ok;
	assign eng_ctrl.ack   = out_load;

	rss_engine #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (eng_ctrl),
		.stat    (eng_stat),
		.mag     (mag),
		.count   (count_q),
		.sum     (sum_q),
		.sum_sq  (sum_sq_q),
		.prod    (eng_prod),
		.mean    (eng_mean),
		.variance(eng_var),
		.std_dev (eng_std),
		.rms     (eng_rms)
	);

	// count, sum, min, max and crossings update on acceptance; the square is
	// folded in during the engine's accumulate state, once it has formed it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_q    <= '0;
			sum_sq_q <= '0;
			min_q    <= '0;
			max_q    <= '0;
			prev_q   <= '0;
			cross_q  <= '0;
		end else if (accept) begin
			if (s_tuser == CMD_CLEAR) begin
				count_q  <= '0;
				sum_q    <= '0;
				sum_sq_q <= '0;
				min_q    <= '0;
				max_q    <= '0;
				prev_q   <= '0;
				cross_q  <= '0;
			end else if (add_ok) begin
				if (count_q == '0) begin
					// first sample sets both extremes, no crossing counted
					min_q <= sample;
					max_q <= sample;
				end else begin
					if (sample < min_q) min_q <= sample;
					if (sample > max_q) max_q <= sample;
					if (crossed && cross_q != CROSS_MAX) begin
						cross_q <= cross_q + 1'b1;
					end
				end
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SUM_W'(sample);
				prev_q  <= sample;
			end
		end else if (eng_stat.acc_en) begin
			// sum of squares wraps at its width
			sum_sq_q <= sum_sq_q + SQ_W'(eng_prod);
		end
	end

	// output register, parts the result side from the input side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= OUT_W'({full,
			                     cross_q,
			                     ROOT_W'(eng_rms),
			                     ROOT_W'(eng_std),
			                     VAR_W'(eng_var),
			                     eng_mean,
			                     max_q,
			                     min_q,
			                     count_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// engine leaves idle right after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input side still ready after a transaction");

	// an empty block holds no leftover statistics
	a_empty_is_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (min_q == '0 && max_q == '0 && cross_q == '0
		                     && sum_q == '0 && sum_sq_q == '0))
		else $error("statistics not zero while count is zero");

	// an added sample bumps the count by exactly one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && add_ok) |=> (count_q == $past(count_q) + 1'b1))
		else $error("count did not advance on an added sample");

	// extremes stay ordered once a sample is in
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (min_q <= max_q))
		else $error("minimum above maximum");

endmodule

`default_nettype wire
